@@ rtl/core/fflpt_pkg.sv @@
package fflpt_pkg;

	// Default number of physical frames
	localparam int NUM_FRAMES_DEF = 256;

	// Configuration port geometry
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int FC_W       = 9;

	// Register index of frame_count (byte address bit 2)
	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ACT_ALLOC      = 2'd0,
		ACT_RELEASE    = 2'd1,
		ACT_SET_HANDLE = 2'd2,
		ACT_READ       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_FREE  = 2'd1,
		STS_RANGE    = 2'd2,
		STS_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR    = 2'd0,
		S_IDLE     = 2'd1,
		S_ENTRY_RD = 2'd2,
		S_EXEC     = 2'd3
	} state_t;

	// One page table entry
	typedef struct packed {
		logic [15:0] pid;
		logic [31:0] vpage;
		logic        refd;
		logic [15:0] handle;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic entry_rd;
		logic exec;
		logic clear_wr;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

@@ rtl/core/fflpt_ctrl.sv @@
module fflpt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             cfg_wr,
	input  fflpt_pkg::stat_t stat,
	output fflpt_pkg::cmd_t  cmd
);

	fflpt_pkg::state_t state_q;
	fflpt_pkg::state_t state_nxt;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fflpt_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fflpt_pkg::S_CLEAR: begin
				if (!cfg_wr && stat.clear_last) begin
					state_nxt = fflpt_pkg::S_IDLE;
				end
			end
			fflpt_pkg::S_IDLE: begin
				if (cfg_wr) begin
					state_nxt = fflpt_pkg::S_CLEAR;
				end else if (in_valid) begin
					state_nxt = fflpt_pkg::S_ENTRY_RD;
				end
			end
			fflpt_pkg::S_ENTRY_RD: begin
				state_nxt = fflpt_pkg::S_EXEC;
			end
			fflpt_pkg::S_EXEC: begin
				if (stat.out_free) begin
					state_nxt = fflpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = fflpt_pkg::S_CLEAR;
			end
		endcase
		// restart the sweep on any frame_count write
		if (cfg_wr) begin
			state_nxt = fflpt_pkg::S_CLEAR;
		end
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			fflpt_pkg::S_CLEAR: begin
				cmd.clear_wr = !cfg_wr;
			end
			fflpt_pkg::S_IDLE: begin
				// hold off the item while frame_count is being written
				in_stall    = cfg_wr;
				cmd.capture = in_valid && !cfg_wr;
			end
			fflpt_pkg::S_ENTRY_RD: begin
				cmd.entry_rd = 1'b1;
			end
			fflpt_pkg::S_EXEC: begin
				cmd.exec = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/core/fflpt_dp.sv @@
module fflpt_dp #(
	parameter int NUM_FRAMES = fflpt_pkg::NUM_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fflpt_pkg::cmd_t             cmd,
	output fflpt_pkg::stat_t            stat,
	input  logic                        cfg_wr,
	input  logic [fflpt_pkg::FC_W-1:0]  cfg_data,
	output logic [fflpt_pkg::FC_W-1:0]  frame_count,
	input  logic [1:0]                  action,
	input  logic [15:0]                 process_id,
	input  logic [31:0]                 virtual_page,
	input  logic [7:0]                  frame,
	input  logic [15:0]                 algo_handle,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [7:0]                  frame_out,
	output logic [15:0]                 pid_out,
	output logic [31:0]                 vpage_out,
	output logic                        referenced,
	output logic [15:0]                 handle_out,
	output logic [8:0]                  in_use_count
);

	localparam int IDX_W = $clog2(NUM_FRAMES);
	localparam int CNT_W = $clog2(NUM_FRAMES + 1);
	localparam int FC_W  = fflpt_pkg::FC_W;
	localparam int FC_RST_I = (NUM_FRAMES < 256) ? NUM_FRAMES : 256;
	localparam int FC_MAX_I = (NUM_FRAMES < 511) ? NUM_FRAMES : 511;
	localparam logic [FC_W-1:0]  FC_RST   = FC_W'(FC_RST_I);
	localparam logic [FC_W-1:0]  FC_MAX   = FC_W'(FC_MAX_I);
	localparam logic [IDX_W-1:0] TAIL_RST = IDX_W'(FC_RST_I % NUM_FRAMES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FRAMES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_FRAMES);

	// Configuration and queue pointers
	logic [FC_W-1:0]  fc_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] alloc_q;
	logic [IDX_W-1:0] clr_idx_q;

	// Captured item
	fflpt_pkg::action_t act_q;
	logic [15:0]        pid_q;
	logic [31:0]        vpage_q;
	logic [7:0]         frame_q;
	logic [15:0]        handle_q;

	// Memories and registered read data
	logic [IDX_W-1:0]  queue_mem [NUM_FRAMES];
	fflpt_pkg::entry_t entry_mem [NUM_FRAMES];
	logic [IDX_W-1:0]  qrd_q;
	fflpt_pkg::entry_t erd_q;

	// Output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  frame_out_q;
	logic [15:0] pid_out_q;
	logic [31:0] vpage_out_q;
	logic        ref_out_q;
	logic [15:0] handle_out_q;
	logic [8:0]  in_use_q;

	// Combinational
	logic [FC_W-1:0]   fc_new;
	logic [IDX_W-1:0]  tail_new;
	logic [IDX_W-1:0]  frame_idx;
	logic [IDX_W-1:0]  ent_addr;
	logic              in_range;
	fflpt_pkg::status_t sts_c;
	logic [7:0]        fout_c;
	logic              show_c;
	logic              ent_wr_c;
	logic              pop_c;
	logic              push_c;
	fflpt_pkg::entry_t new_ent;
	logic [CNT_W-1:0]  alloc_nxt;
	logic              q_we;
	logic [IDX_W-1:0]  q_waddr;
	logic [IDX_W-1:0]  q_wdata;
	logic              e_we;
	logic [IDX_W-1:0]  e_waddr;
	fflpt_pkg::entry_t e_wdata;

	// Saturate a new frame_count and derive the matching tail
	assign fc_new   = (cfg_data > FC_MAX) ? FC_MAX : cfg_data;
	assign tail_new = (CNT_W'(fc_new) == CNT_FULL) ? '0 : IDX_W'(fc_new);

	assign frame_idx = IDX_W'(frame_q);
	assign ent_addr  = (act_q == fflpt_pkg::ACT_ALLOC) ? qrd_q : frame_idx;
	assign in_range  = {1'b0, frame_q} < fc_q;

	// Decide the action's effect
	always_comb begin
		sts_c    = fflpt_pkg::STS_OK;
		fout_c   = frame_q;
		show_c   = 1'b0;
		ent_wr_c = 1'b0;
		pop_c    = 1'b0;
		push_c   = 1'b0;
		new_ent  = erd_q;
		case (act_q)
			fflpt_pkg::ACT_ALLOC: begin
				if (free_q == '0) begin
					sts_c  = fflpt_pkg::STS_NO_FREE;
					fout_c = '0;
				end else begin
					fout_c         = 8'(qrd_q);
					new_ent.pid    = pid_q;
					new_ent.vpage  = vpage_q;
					new_ent.refd   = 1'b1;
					new_ent.handle = '0;
					ent_wr_c       = 1'b1;
					pop_c          = 1'b1;
					show_c         = 1'b1;
				end
			end
			default: begin
				if (!in_range) begin
					sts_c = fflpt_pkg::STS_RANGE;
				end else begin
					case (act_q)
						fflpt_pkg::ACT_RELEASE: begin
							if (!erd_q.refd) begin
								sts_c = fflpt_pkg::STS_NOT_USED;
							end else begin
								// keep the handle, drop the rest
								new_ent.pid   = '0;
								new_ent.vpage = '0;
								new_ent.refd  = 1'b0;
								ent_wr_c      = 1'b1;
								push_c        = 1'b1;
								show_c        = 1'b1;
							end
						end
						fflpt_pkg::ACT_SET_HANDLE: begin
							new_ent.handle = handle_q;
							ent_wr_c       = 1'b1;
							show_c         = 1'b1;
						end
						default: begin
							show_c = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

	// Allocated count after this action
	always_comb begin
		alloc_nxt = alloc_q;
		if (pop_c) begin
			alloc_nxt = alloc_q + 1'b1;
		end else if (push_c && alloc_q != '0) begin
			alloc_nxt = alloc_q - 1'b1;
		end
	end

	// Memory write ports: the sweep owns them while clearing
	assign q_we    = cmd.clear_wr || (cmd.exec && push_c);
	assign q_waddr = cmd.clear_wr ? clr_idx_q : tail_q;
	assign q_wdata = cmd.clear_wr ? clr_idx_q : frame_idx;
	assign e_we    = cmd.clear_wr || (cmd.exec && ent_wr_c);
	assign e_waddr = cmd.clear_wr ? clr_idx_q : ent_addr;
	assign e_wdata = cmd.clear_wr ? '0 : new_ent;

	// Free queue memory; read the head slot when an item comes in
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		if (cmd.capture) begin
			qrd_q <= queue_mem[head_q];
		end
	end

	// Page table memory
	always_ff @(posedge clk) begin
		if (e_we) begin
			entry_mem[e_waddr] <= e_wdata;
		end
		if (cmd.entry_rd) begin
			erd_q <= entry_mem[ent_addr];
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= fflpt_pkg::action_t'(action);
			pid_q    <= process_id;
			vpage_q  <= virtual_page;
			frame_q  <= frame;
			handle_q <= algo_handle;
		end
	end

	// Configuration, queue pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= FC_RST;
			head_q    <= '0;
			tail_q    <= TAIL_RST;
			free_q    <= CNT_W'(FC_RST);
			alloc_q   <= '0;
			clr_idx_q <= '0;
		end else if (cfg_wr) begin
			fc_q      <= fc_new;
			head_q    <= '0;
			tail_q    <= tail_new;
			free_q    <= CNT_W'(fc_new);
			alloc_q   <= '0;
			clr_idx_q <= '0;
		end else begin
			if (cmd.clear_wr) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.exec) begin
				alloc_q <= alloc_nxt;
				if (pop_c) begin
					head_q <= (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
					free_q <= free_q - 1'b1;
				end
				if (push_c) begin
					tail_q <= (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
					free_q <= free_q + 1'b1;
				end
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= sts_c;
			frame_out_q  <= fout_c;
			pid_out_q    <= show_c ? new_ent.pid : '0;
			vpage_out_q  <= show_c ? new_ent.vpage : '0;
			ref_out_q    <= show_c ? new_ent.refd : 1'b0;
			handle_out_q <= show_c ? new_ent.handle : '0;
			in_use_q     <= 9'(alloc_nxt);
		end
	end

	assign stat.clear_last = (clr_idx_q == IDX_LAST);
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign frame_count  = fc_q;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_out    = frame_out_q;
	assign pid_out      = pid_out_q;
	assign vpage_out    = vpage_out_q;
	assign referenced   = ref_out_q;
	assign handle_out   = handle_out_q;
	assign in_use_count = in_use_q;

	// Every frame counted is either free or allocated
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_q) + 32'(alloc_q) == 32'(fc_q))
		else $error("free and allocated counts do not add up to frame_count");

	// Pointers meet only when the queue is empty or full
	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (free_q == '0 || free_q == CNT_FULL))
		else $error("queue pointers disagree with free count");

	// Never overwrite a result that is still waiting
	a_exec_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

endmodule

@@ rtl/core/frame_free_list_page_table.sv @@
// Frame free list with an inverted page table. Each item carries an action
// (allocate, release, set handle, read) and yields exactly one result. An item
// goes through an accept step (free queue head is read), an entry read from
// the page table memory, and an execute step that updates the table and queue
// and loads the result register, waiting while a stalled result still holds
// it. The next item can be accepted in the cycle after the execute step, not
// before, since the queue read feeds the entry read. The result register lets
// the next item enter while a result is still stalled. After reset and after
// every frame_count write the block runs a clearing pass over every frame
// index, with in_stall high, that zeroes every entry and refills the free
// queue in ascending frame order. frame_count sits at byte address 0; written
// values above NUM_FRAMES saturate, and writes are only expected while idle.
module frame_free_list_page_table #(
	parameter int NUM_FRAMES = fflpt_pkg::NUM_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fflpt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [fflpt_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [fflpt_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [15:0]                       process_id,
	input  logic [31:0]                       virtual_page,
	input  logic [7:0]                        frame,
	input  logic [15:0]                       algo_handle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [7:0]                        frame_out,
	output logic [15:0]                       pid_out,
	output logic [31:0]                       vpage_out,
	output logic                              referenced,
	output logic [15:0]                       handle_out,
	output logic [8:0]                        in_use_count
);

	localparam int FC_W = fflpt_pkg::FC_W;

	fflpt_pkg::cmd_t  cmd;
	fflpt_pkg::stat_t stat;
	logic             reg_hit;
	logic             cfg_wr;
	logic [FC_W-1:0]  frame_count;

	// Decode the register port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[fflpt_pkg::CFG_ADDR_W-1] == fflpt_pkg::REG_FRAME_COUNT);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? fflpt_pkg::CFG_DATA_W'(frame_count) : '0;

	fflpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cfg_wr   (cfg_wr),
		.stat     (stat),
		.cmd      (cmd)
	);

	fflpt_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr       (cfg_wr),
		.cfg_data     (pwdata[FC_W-1:0]),
		.frame_count  (frame_count),
		.action       (action),
		.process_id   (process_id),
		.virtual_page (virtual_page),
		.frame        (frame),
		.algo_handle  (algo_handle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_out    (frame_out),
		.pid_out      (pid_out),
		.vpage_out    (vpage_out),
		.referenced   (referenced),
		.handle_out   (handle_out),
		.in_use_count (in_use_count)
	);

endmodule
